// ----- design/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the slab object allocator
// Holds list tags, result status codes, the controller command struct and
// the default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package soa_pkg;

  localparam int unsigned NumSlabsDef     = 16;
  localparam int unsigned SlotsPerSlabDef = 32;
  localparam int unsigned PageBytesDef    = 4096;

  localparam logic [4:0] LinkNil = 5'd31;

  localparam logic [0:0] CfgObjSize   = 1'b0;
  localparam logic [0:0] CfgPoolFrame = 1'b1;

  typedef enum logic [1:0] {
    TagUnused  = 2'd0,
    TagPartial = 2'd1,
    TagFull    = 2'd2,
    TagEmpty   = 2'd3
  } list_tag_e;

  typedef enum logic [1:0] {
    StDone      = 2'd0,
    StExhausted = 2'd1,
    StBadAddr   = 2'd2,
    StBadSlot   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OpNone,
    OpStart,      // latch request, start capacity division
    OpDivStep,    // one restoring division step
    OpAllocPick,  // choose partial head or obtain a new slab
    OpScan,       // one slot of the lowest-free scan
    OpAllocCommit,
    OpFreeLocate,
    OpFreeCommit,
    OpWalk,       // one link of the unlink walk
    OpRelink,
    OpRespond
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic walk_done;
    logic is_free;
    logic early_exit;  // request ends early with a failure status
    logic need_walk;   // relink needed (on a free, after an unlink walk)
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/slab_object_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// slab_object_allocator_unit: bitmap slab allocator for one object cache
// Top level joining the request sequencer and the slab datapath.
// ----------------------------------------------------------------------------
// Usage: a request transfer (func_i, obj_addr_i) is taken when in_valid_i is
// high and in_stall_o is low. One request is worked on at a time; each
// produces exactly one result transfer (status_o, result_addr_o), taken when
// out_valid_o is high and out_stall_i is low. The result register holds its
// value while the receiver stalls, and no new request is taken until it has
// been transferred.
// Sequence: a serial restoring divider computes the slab capacity. An
// allocation then scans the slot bitmap one slot per cycle, twice; a free
// runs a second division for the slot index and, when the slab changes
// list, an unlink walk.
// Configuration writes (object size, pool frame) are to go in only while
// idle; the user must keep to this, as the block itself does not enforce it.
// Reset clears all lists, bitmaps and counters at once.
// ----------------------------------------------------------------------------
`default_nettype none

module slab_object_allocator_unit
  import soa_pkg::*;
#(
  parameter int unsigned NumSlabs     = NumSlabsDef,
  parameter int unsigned SlotsPerSlab = SlotsPerSlabDef,
  parameter int unsigned PageBytes    = PageBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [31:0] obj_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_addr_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  soa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  soa_datapath #(
    .NumSlabs(NumSlabs), .SlotsPerSlab(SlotsPerSlab), .PageBytes(PageBytes)
  ) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .func_i, .obj_addr_i,
    .cmd_i(cmd), .stat_o(stat), .status_o, .result_addr_o
  );

endmodule

`default_nettype wire

// ----- design/soa_datapath.sv -----
// ----------------------------------------------------------------------------
// soa_datapath: slab state, serial divider, slot scan and list relinking
// Executes one micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_datapath
  import soa_pkg::*;
#(
  parameter int unsigned NumSlabs     = NumSlabsDef,
  parameter int unsigned SlotsPerSlab = SlotsPerSlabDef,
  parameter int unsigned PageBytes    = PageBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        func_i,
  input  wire logic [31:0] obj_addr_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  output logic [1:0]       status_o,
  output logic [31:0]      result_addr_o
);

  localparam int unsigned SW = $clog2(NumSlabs + 1) > 1 ? $clog2(NumSlabs + 1) : 1;
  localparam int unsigned PB = $clog2(PageBytes);
  localparam int unsigned DW = PB + 1;  // dividend width, holds PageBytes
  localparam logic [5:0]  SlotsMax = 6'(SlotsPerSlab);

  logic [12:0] obj_bytes_q;
  logic [19:0] pool_frame_q;

  logic [31:0] bitmap_q [NumSlabs];
  logic [5:0]  fcnt_q   [NumSlabs];
  logic [4:0]  link_q   [NumSlabs];
  logic [1:0]  tag_q    [NumSlabs];
  logic [4:0]  phead_q, fhead_q, ehead_q;
  logic [SW-1:0] created_q;

  logic        func_q;
  logic [31:0] addr_q;
  logic [12:0] esize_q;
  // restoring divider: quotient/remainder of dividend by esize
  logic [DW-1:0] dquo_q;
  logic [12:0]   drem_q;
  logic [4:0]    dcnt_q;
  logic [5:0]    cap_q;
  logic [4:0]    slab_q;
  logic [5:0]    scan_q;
  logic          found_q;
  logic [4:0]    cur_q;
  logic [4:0]    wcnt_q;
  logic [1:0]    st_q;
  logic [31:0]   res_q;
  logic          early_q;
  logic          walk_q;
  logic          wdone_q;
  logic [1:0]    rtag_q;  // list being unlinked from
  logic [1:0]    dtag_q;  // list to push onto

  wire [12:0] esize_w = (obj_bytes_q == 13'd0) ? 13'd1 : obj_bytes_q;
  wire [31:0] offs  = addr_q - 32'(({12'd0, pool_frame_q}) * PageBytes);
  wire [31:0] kidx  = offs >> PB;
  wire [4:0]  sidx  = slab_q;
  wire [31:0] cur_bm = bitmap_q[sidx[$clog2(NumSlabs)-1:0]];

  logic [13:0] rem_sh;
  assign rem_sh = {drem_q, dquo_q[DW-1]};

  function automatic logic [4:0] head_for(logic [1:0] t, logic [4:0] p, logic [4:0] f,
                                          logic [4:0] e);
    logic [4:0] h;
    h = (t == TagPartial) ? p : (t == TagFull) ? f : e;
    return h;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_bytes_q  <= 13'd64;
      pool_frame_q <= '0;
      for (int k = 0; k < NumSlabs; k++) begin
        bitmap_q[k] <= '0;
        fcnt_q[k]   <= '0;
        link_q[k]   <= LinkNil;
        tag_q[k]    <= TagUnused;
      end
      phead_q   <= LinkNil;
      fhead_q   <= LinkNil;
      ehead_q   <= LinkNil;
      created_q <= '0;
      early_q   <= 1'b0;
      walk_q    <= 1'b0;
      wdone_q   <= 1'b0;
      dcnt_q    <= '0;
      found_q   <= 1'b0;
      func_q    <= 1'b0;
      addr_q    <= '0;
      esize_q   <= 13'd1;
      dquo_q    <= '0;
      drem_q    <= '0;
      cap_q     <= '0;
      slab_q    <= '0;
      scan_q    <= '0;
      cur_q     <= LinkNil;
      wcnt_q    <= '0;
      st_q      <= StDone;
      res_q     <= '0;
      rtag_q    <= TagUnused;
      dtag_q    <= TagUnused;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgObjSize) obj_bytes_q <= cfg_wdata_i[12:0];
        else pool_frame_q <= cfg_wdata_i;
      end
      unique case (cmd_i.op)
        OpStart: begin
          func_q  <= func_i;
          addr_q  <= obj_addr_i;
          esize_q <= esize_w;
          dquo_q  <= DW'(PageBytes);
          drem_q  <= '0;
          dcnt_q  <= 5'(DW);
          early_q <= 1'b0;
          walk_q  <= 1'b0;
          st_q    <= StDone;
          res_q   <= '0;
        end
        OpDivStep: begin
          // The partial remainder always stays below the object size.
          if (rem_sh >= {1'b0, esize_q}) begin
            drem_q <= 13'(rem_sh - {1'b0, esize_q});
            dquo_q <= {dquo_q[DW-2:0], 1'b1};
          end else begin
            drem_q <= rem_sh[12:0];
            dquo_q <= {dquo_q[DW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 5'd1;
        end
        OpAllocPick: begin
          cap_q  <= (dquo_q > DW'(SlotsPerSlab)) ? SlotsMax : 6'(dquo_q);
          scan_q <= '0;
          found_q <= 1'b0;
          if (dquo_q == '0) begin
            st_q <= StExhausted; early_q <= 1'b1;
          end else if (phead_q < 5'(NumSlabs)) begin
            slab_q <= phead_q;
          end else if (ehead_q < 5'(NumSlabs)) begin
            slab_q  <= ehead_q;
            ehead_q <= link_q[ehead_q[$clog2(NumSlabs)-1:0]];
            bitmap_q[ehead_q[$clog2(NumSlabs)-1:0]] <= '0;
            fcnt_q[ehead_q[$clog2(NumSlabs)-1:0]] <=
                (dquo_q > DW'(SlotsPerSlab)) ? SlotsMax : 6'(dquo_q);
            link_q[ehead_q[$clog2(NumSlabs)-1:0]] <= phead_q;
            tag_q[ehead_q[$clog2(NumSlabs)-1:0]]  <= TagPartial;
            phead_q <= ehead_q;
          end else if (created_q < SW'(NumSlabs)) begin
            slab_q    <= 5'(created_q);
            created_q <= created_q + 1'b1;
            bitmap_q[created_q[$clog2(NumSlabs)-1:0]] <= '0;
            fcnt_q[created_q[$clog2(NumSlabs)-1:0]] <=
                (dquo_q > DW'(SlotsPerSlab)) ? SlotsMax : 6'(dquo_q);
            link_q[created_q[$clog2(NumSlabs)-1:0]] <= phead_q;
            tag_q[created_q[$clog2(NumSlabs)-1:0]]  <= TagPartial;
            phead_q <= 5'(created_q);
          end else begin
            st_q <= StExhausted; early_q <= 1'b1;
          end
        end
        OpScan: begin
          if (!found_q && scan_q < cap_q) begin
            if (!cur_bm[scan_q[4:0]]) found_q <= 1'b1;
            else scan_q <= scan_q + 6'd1;
          end
        end
        OpAllocCommit: begin
          if (!found_q) begin
            // no free slot below the capacity: move to the full list
            st_q    <= StExhausted;
            early_q <= 1'b1;
            phead_q <= link_q[sidx[$clog2(NumSlabs)-1:0]];
            link_q[sidx[$clog2(NumSlabs)-1:0]] <= fhead_q;
            tag_q[sidx[$clog2(NumSlabs)-1:0]]  <= TagFull;
            fhead_q <= slab_q;
          end else begin
            bitmap_q[sidx[$clog2(NumSlabs)-1:0]] <= cur_bm | (32'd1 << scan_q[4:0]);
            res_q <= 32'((({12'd0, pool_frame_q} + 32'(slab_q)) * PageBytes)
                         + 32'(scan_q) * 32'(esize_q));
            if (fcnt_q[sidx[$clog2(NumSlabs)-1:0]] != 6'd0)
              fcnt_q[sidx[$clog2(NumSlabs)-1:0]] <= fcnt_q[sidx[$clog2(NumSlabs)-1:0]] - 6'd1;
            // re-scan and free count decide fullness after the update
            scan_q  <= '0;
            found_q <= 1'b0;
            walk_q  <= (fcnt_q[sidx[$clog2(NumSlabs)-1:0]] <= 6'd1);
          end
        end
        OpFreeLocate: begin
          // divide in-page offset by object size
          dquo_q <= DW'(offs[PB-1:0]);
          drem_q <= '0;
          dcnt_q <= 5'(DW);
          if (addr_q == 32'd0 || kidx >= 32'(created_q) || kidx >= 32'(NumSlabs)) begin
            st_q <= StBadAddr; early_q <= 1'b1;
          end else begin
            slab_q <= 5'(kidx);
          end
        end
        OpFreeCommit: begin
          if (32'(dquo_q) >= 32'(cap_q) || !cur_bm[dquo_q[4:0]]) begin
            st_q <= StBadSlot; early_q <= 1'b1;
          end else begin
            bitmap_q[sidx[$clog2(NumSlabs)-1:0]] <= cur_bm & ~(32'd1 << dquo_q[4:0]);
            if (fcnt_q[sidx[$clog2(NumSlabs)-1:0]] != 6'd63)
              fcnt_q[sidx[$clog2(NumSlabs)-1:0]] <= fcnt_q[sidx[$clog2(NumSlabs)-1:0]] + 6'd1;
            rtag_q <= tag_q[sidx[$clog2(NumSlabs)-1:0]];
            if ((cur_bm & ~(32'd1 << dquo_q[4:0])) == 32'd0) begin
              dtag_q <= TagEmpty;
              walk_q <= (tag_q[sidx[$clog2(NumSlabs)-1:0]] == TagPartial) ||
                        (tag_q[sidx[$clog2(NumSlabs)-1:0]] == TagFull);
            end else begin
              dtag_q <= TagPartial;
              walk_q <= (tag_q[sidx[$clog2(NumSlabs)-1:0]] == TagFull);
            end
            cur_q   <= head_for(tag_q[sidx[$clog2(NumSlabs)-1:0]], phead_q, fhead_q,
                                ehead_q);
            wcnt_q  <= '0;
            wdone_q <= 1'b0;
          end
        end
        OpWalk: begin
          if (!wdone_q) begin
            if (cur_q == slab_q) begin
              // slab is the head of its list
              unique case (rtag_q)
                TagPartial: phead_q <= link_q[sidx[$clog2(NumSlabs)-1:0]];
                TagFull:    fhead_q <= link_q[sidx[$clog2(NumSlabs)-1:0]];
                default:    ehead_q <= link_q[sidx[$clog2(NumSlabs)-1:0]];
              endcase
              link_q[sidx[$clog2(NumSlabs)-1:0]] <= LinkNil;
              wdone_q <= 1'b1;
            end else if (cur_q >= 5'(NumSlabs) || wcnt_q >= 5'(NumSlabs)) begin
              wdone_q <= 1'b1;
            end else if (link_q[cur_q[$clog2(NumSlabs)-1:0]] == slab_q) begin
              link_q[cur_q[$clog2(NumSlabs)-1:0]] <= link_q[sidx[$clog2(NumSlabs)-1:0]];
              link_q[sidx[$clog2(NumSlabs)-1:0]]  <= LinkNil;
              wdone_q <= 1'b1;
            end else begin
              cur_q  <= link_q[cur_q[$clog2(NumSlabs)-1:0]];
              wcnt_q <= wcnt_q + 5'd1;
            end
          end
        end
        OpRelink: begin
          if (!func_q) begin
            // allocation filled the slab: free count or scan result decides
            if (walk_q || !found_q) begin
              phead_q <= link_q[sidx[$clog2(NumSlabs)-1:0]];
              link_q[sidx[$clog2(NumSlabs)-1:0]] <= fhead_q;
              tag_q[sidx[$clog2(NumSlabs)-1:0]]  <= TagFull;
              fhead_q <= slab_q;
            end
          end else if (walk_q) begin
            tag_q[sidx[$clog2(NumSlabs)-1:0]] <= dtag_q;
            if (dtag_q == TagEmpty) begin
              link_q[sidx[$clog2(NumSlabs)-1:0]] <= ehead_q;
              ehead_q <= slab_q;
            end else begin
              link_q[sidx[$clog2(NumSlabs)-1:0]] <= phead_q;
              phead_q <= slab_q;
            end
          end
        end
        default: ;
      endcase
      if (cmd_i.op == OpFreeLocate) begin
        cap_q <= (dquo_q > DW'(SlotsPerSlab)) ? SlotsMax : 6'(dquo_q);
      end
    end
  end

  assign stat_o.div_done   = (dcnt_q == 5'd0);
  assign stat_o.scan_done  = found_q || (scan_q >= cap_q);
  assign stat_o.walk_done  = wdone_q;
  assign stat_o.is_free    = func_q;
  assign stat_o.early_exit = early_q;
  assign stat_o.need_walk  = walk_q;
  assign status_o      = st_q;
  assign result_addr_o = res_q;

endmodule

`default_nettype wire

// ----- design/soa_ctrl.sv -----
// ----------------------------------------------------------------------------
// soa_ctrl: request sequencer of the slab object allocator
// Steps the datapath through division, search, commit, unlink walk and relink phases.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_ctrl
  import soa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [11:0] {
    SIdle   = 12'b000000000001,
    SDiv    = 12'b000000000010,
    SPick   = 12'b000000000100,
    SScan   = 12'b000000001000,
    SACom   = 12'b000000010000,
    SRescan = 12'b000000100000,
    SLoc    = 12'b000001000000,
    SDiv2   = 12'b000010000000,
    SFCom   = 12'b000100000000,
    SWalk   = 12'b001000000000,
    SRelink = 12'b010000000000,
    SOut    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q && out_stall_i;
    cmd_o.op   = OpNone;
    unique case (state_q)
      SIdle: if (in_valid_i && !ovalid_q) begin
        cmd_o.op = OpStart; state_d = SDiv;
      end
      SDiv: begin
        if (stat_i.div_done) begin
          if (stat_i.is_free) begin cmd_o.op = OpFreeLocate; state_d = SDiv2; end
          else begin cmd_o.op = OpAllocPick; state_d = SScan; end
        end else cmd_o.op = OpDivStep;
      end
      SPick: state_d = SScan;
      SScan: begin
        if (stat_i.early_exit) state_d = SOut;
        else if (stat_i.scan_done) begin cmd_o.op = OpAllocCommit; state_d = SACom; end
        else cmd_o.op = OpScan;
      end
      SACom: begin
        // A commit without a free slot has already moved the slab to the full list.
        if (stat_i.early_exit) state_d = SOut;
        else state_d = SRescan;
      end
      SRescan: begin
        if (stat_i.scan_done) begin cmd_o.op = OpRelink; state_d = SOut; end
        else cmd_o.op = OpScan;
      end
      SLoc: state_d = SDiv2;
      SDiv2: begin
        if (stat_i.early_exit) state_d = SOut;
        else if (stat_i.div_done) begin cmd_o.op = OpFreeCommit; state_d = SFCom; end
        else cmd_o.op = OpDivStep;
      end
      SFCom: begin
        if (stat_i.early_exit || !stat_i.need_walk) state_d = SOut;
        else state_d = SWalk;
      end
      SWalk: begin
        if (stat_i.walk_done) begin cmd_o.op = OpRelink; state_d = SOut; end
        else cmd_o.op = OpWalk;
      end
      SRelink: state_d = SOut;
      SOut: begin ovalid_d = 1'b1; state_d = SIdle; end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != SIdle) || ovalid_q;
  assign out_valid_o = ovalid_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q) else $error("result dropped");
  a_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> in_stall_o) else $error("accept while result pending");

endmodule

`default_nettype wire
